// ===== rtl/core/scwd_pkg.sv =====
// ----------------------------------------------------------------------------
// scwd_pkg
// Shared types and constants for the scan cluster width detector.
// ----------------------------------------------------------------------------
package scwd_pkg;

	localparam int MAX_POINTS     = 1024;
	localparam int IDX_W          = $clog2(MAX_POINTS);
	localparam int TRIG_FRAC_BITS = 15;
	localparam int CORDIC_ITERS   = (TRIG_FRAC_BITS < 24) ? TRIG_FRAC_BITS : 24;
	localparam int IT_W           = $clog2(CORDIC_ITERS + 1);
	localparam int CW             = TRIG_FRAC_BITS + 3;
	localparam int ZW             = 24;
	localparam int QD             = 2;
	localparam int QP_W           = $clog2(QD);

	localparam logic [2:0] REG_ANGLE_START = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [2:0] REG_JOIN_DIST   = 3'd2;
	localparam logic [2:0] REG_WIDTH_MIN   = 3'd3;
	localparam logic [2:0] REG_WIDTH_MAX   = 3'd4;

	localparam logic [63:0] CORDIC_K_Q30 = 64'd652032874;

	// item as classified by the front end
	typedef struct packed {
		logic [15:0]      range_mm;
		logic             last;
		logic             first;
		logic [1:0]       quad;
		logic [13:0]      frac;
	} item_t;

	function automatic logic signed [ZW:0] atan_val(input logic [4:0] i);
		case (i)
			5'd0:    atan_val = 25'sd2097152;
			5'd1:    atan_val = 25'sd1238021;
			5'd2:    atan_val = 25'sd654136;
			5'd3:    atan_val = 25'sd332050;
			5'd4:    atan_val = 25'sd166669;
			5'd5:    atan_val = 25'sd83416;
			5'd6:    atan_val = 25'sd41718;
			5'd7:    atan_val = 25'sd20860;
			5'd8:    atan_val = 25'sd10430;
			5'd9:    atan_val = 25'sd5215;
			5'd10:   atan_val = 25'sd2608;
			5'd11:   atan_val = 25'sd1304;
			5'd12:   atan_val = 25'sd652;
			5'd13:   atan_val = 25'sd326;
			5'd14:   atan_val = 25'sd163;
			5'd15:   atan_val = 25'sd81;
			5'd16:   atan_val = 25'sd41;
			5'd17:   atan_val = 25'sd20;
			5'd18:   atan_val = 25'sd10;
			5'd19:   atan_val = 25'sd5;
			5'd20:   atan_val = 25'sd3;
			5'd21:   atan_val = 25'sd1;
			5'd22:   atan_val = 25'sd1;
			default: atan_val = 25'sd0;
		endcase
	endfunction

endpackage

// ===== rtl/core/scwd_front.sv =====
// ----------------------------------------------------------------------------
// scwd_front
// Accepts samples, tracks the sample index and works out the quadrant angle.
// ----------------------------------------------------------------------------
module scwd_front import scwd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       range_mm,
	input  logic              last_in_scan,
	input  logic [15:0]       angle_start,
	input  logic [15:0]       angle_step,
	output logic              q_push,
	output item_t             q_item,
	input  logic              q_full
);
	logic [IDX_W-1:0] count_q;
	logic [IDX_W+15:0] prod;
	logic [15:0]       ang;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign prod     = count_q * angle_step;
	assign ang      = angle_start + prod[15:0];

	always_comb begin
		q_item.range_mm = range_mm;
		q_item.last     = last_in_scan;
		q_item.first    = (count_q == '0);
		q_item.quad     = ang[15:14];
		q_item.frac     = ang[13:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			if (last_in_scan)
				count_q <= '0;
			else if (count_q != IDX_W'(MAX_POINTS - 1))
				count_q <= count_q + 1'b1;
		end
	end
endmodule

// ===== rtl/core/scwd_queue.sv =====
// ----------------------------------------------------------------------------
// scwd_queue
// Short queue between the front end and the cluster engine.
// ----------------------------------------------------------------------------
module scwd_queue import scwd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  not_empty
);
	item_t         mem_q [QD];
	logic [QP_W-1:0] wr_q, rd_q;
	logic [QP_W:0]   cnt_q;

	assign full      = (cnt_q == (QP_W+1)'(QD));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QP_W'(QD - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QP_W'(QD - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (QP_W+1)'(push) - (QP_W+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/scwd_back.sv =====
// ----------------------------------------------------------------------------
// scwd_back
// CORDIC, range scaling, cluster tracking and result register.
// ----------------------------------------------------------------------------
module scwd_back import scwd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	input  logic [15:0]       join_distance_mm,
	input  logic [15:0]       width_min_mm,
	input  logic [15:0]       width_max_mm,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [9:0]        first_index,
	output logic signed [16:0] pos_x_mm,
	output logic signed [16:0] pos_y_mm
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_ROT, ST_MUL, ST_RND, ST_DIST, ST_JUDGE, ST_FIN
	} state_t;

	localparam logic signed [CW-1:0] X0 =
		CW'((CORDIC_K_Q30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
	localparam logic signed [49:0] HALF = 50'sd1 <<< (TRIG_FRAC_BITS - 1);

	state_t state_q;
	item_t  it_q;
	logic [IDX_W-1:0] idx_q, start_idx_q, hit_idx_q;
	logic [IT_W-1:0]  it_cnt_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW:0]   z_q;
	logic signed [49:0]   px_q, py_q;
	logic signed [16:0]   x_q, y_q, prev_x_q, prev_y_q, start_x_q, start_y_q;
	logic signed [16:0]   hit_x_q, hit_y_q;
	logic                 hit_q, brk_q;
	logic [34:0]          w2_q;

	logic signed [CW-1:0] dx, dy, c, s;
	logic signed [49:0]   rx, ry;
	logic signed [17:0]   ax, ay, ex, ey;
	logic [34:0]          d2, w2, j2, lo2, hi2;
	logic                 pass;
	logic                 emit;

	assign dx = cy_q >>> it_cnt_q;
	assign dy = cx_q >>> it_cnt_q;

	always_comb begin
		unique case (it_q.quad)
			2'd0:    begin c = cx_q;  s = cy_q;  end
			2'd1:    begin c = -cy_q; s = cx_q;  end
			2'd2:    begin c = -cx_q; s = -cy_q; end
			default: begin c = cy_q;  s = -cx_q; end
		endcase
	end

	function automatic logic signed [16:0] sat17(input logic signed [49:0] v);
		if (v < -50'sd65536)     sat17 = -17'sd65536;
		else if (v > 50'sd65535) sat17 = 17'sd65535;
		else                     sat17 = v[16:0];
	endfunction

	assign rx = (px_q + HALF) >>> TRIG_FRAC_BITS;
	assign ry = (py_q + HALF) >>> TRIG_FRAC_BITS;

	// distance to the previous point, and width of the cluster ending there (or at this point on the last sample)
	assign ax = 18'(x_q) - 18'(prev_x_q);
	assign ay = 18'(y_q) - 18'(prev_y_q);
	assign d2 = 35'(ax * ax) + 35'(ay * ay);
	assign ex = (it_q.last && !brk_q ? 18'(x_q) : 18'(prev_x_q)) - 18'(start_x_q);
	assign ey = (it_q.last && !brk_q ? 18'(y_q) : 18'(prev_y_q)) - 18'(start_y_q);
	assign w2 = 35'(ex * ex) + 35'(ey * ey);
	assign j2  = 35'(join_distance_mm * join_distance_mm);
	assign lo2 = 35'(width_min_mm * width_min_mm);
	assign hi2 = 35'(width_max_mm * width_max_mm);
	assign pass = !hit_q && w2_q >= lo2 && w2_q <= hi2;

	// scan result leaves once the output register is free
	assign emit  = (state_q == ST_FIN) && !brk_q && (!out_valid || out_ready);
	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				it_q <= q_item;
				cx_q <= X0;
				cy_q <= '0;
				z_q  <= (ZW+1)'({q_item.frac, 8'd0});
			end
			ST_ROT: begin
				if (!z_q[ZW]) begin
					cx_q <= cx_q - dx; cy_q <= cy_q + dy;
					z_q  <= z_q - atan_val(5'(it_cnt_q));
				end else begin
					cx_q <= cx_q + dx; cy_q <= cy_q - dy;
					z_q  <= z_q + atan_val(5'(it_cnt_q));
				end
			end
			ST_MUL: begin
				px_q <= 50'($signed({1'b0, it_q.range_mm}) * c);
				py_q <= 50'($signed({1'b0, it_q.range_mm}) * s);
			end
			ST_RND: begin
				x_q <= sat17(rx);
				y_q <= sat17(ry);
			end
			ST_JUDGE: w2_q <= w2;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_cnt_q <= '0;
			idx_q <= '0; start_idx_q <= '0; hit_idx_q <= '0;
			prev_x_q <= '0; prev_y_q <= '0; start_x_q <= '0; start_y_q <= '0;
			hit_x_q <= '0; hit_y_q <= '0; hit_q <= 1'b0; brk_q <= 1'b0;
			out_valid <= 1'b0;
			found <= 1'b0; first_index <= '0; pos_x_mm <= '0; pos_y_mm <= '0;
		end else begin
			if (out_valid && out_ready && !emit)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					it_cnt_q <= '0;
					if (q_pop) state_q <= ST_ROT;
				end
				ST_ROT: begin
					it_cnt_q <= it_cnt_q + 1'b1;
					if (it_cnt_q == IT_W'(CORDIC_ITERS - 1)) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_RND;
				ST_RND: state_q <= ST_DIST;
				ST_DIST: begin
					brk_q <= !it_q.first && (d2 >= j2);
					if (it_q.first) begin
						start_x_q <= x_q; start_y_q <= y_q; start_idx_q <= idx_q;
					end
					state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					// break judges old cluster first, then the last one if needed
					if (brk_q || it_q.last) state_q <= ST_FIN;
					else begin
						prev_x_q <= x_q; prev_y_q <= y_q;
						if (idx_q != IDX_W'(MAX_POINTS - 1)) idx_q <= idx_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					if (brk_q) begin
						if (pass) begin
							hit_q <= 1'b1; hit_idx_q <= start_idx_q;
							hit_x_q <= start_x_q; hit_y_q <= start_y_q;
						end
						start_x_q <= x_q; start_y_q <= y_q; start_idx_q <= idx_q;
						brk_q <= 1'b0;
						prev_x_q <= x_q; prev_y_q <= y_q;
						if (it_q.last) state_q <= ST_JUDGE;
						else begin
							if (idx_q != IDX_W'(MAX_POINTS - 1)) idx_q <= idx_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end else if (emit) begin
						out_valid   <= 1'b1;
						found       <= hit_q || pass;
						first_index <= pass ? 10'(start_idx_q) : (hit_q ? 10'(hit_idx_q) : '0);
						pos_x_mm    <= pass ? start_x_q : (hit_q ? hit_x_q : '0);
						pos_y_mm    <= pass ? start_y_q : (hit_q ? hit_y_q : '0);
						idx_q <= '0; start_idx_q <= '0; hit_idx_q <= '0;
						prev_x_q <= '0; prev_y_q <= '0; start_x_q <= '0; start_y_q <= '0;
						hit_x_q <= '0; hit_y_q <= '0; hit_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/scan_cluster_width_detector_core.sv =====
// ----------------------------------------------------------------------------
// scan_cluster_width_detector_core
// Lidar scan segmentation: polar to xy, clustering, width check per scan.
// ----------------------------------------------------------------------------
// channel | signals                              | direction
// in      | in_valid/in_ready, range_mm, last_in_scan | sink
// out     | out_valid/out_ready, found, first_index, pos_x_mm, pos_y_mm | source
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | sink
// in the back end a sample is popped, rotated through 15 CORDIC iterations on
// the shared rotator, multiplied, rounded, then checked for distance and judged;
// a cluster break or the last sample of a scan adds a finish step, and a break
// on the last sample adds finish, judge and finish again.
// the front end takes samples into a two-entry queue while the back end works.
// the back end waits at the end of a scan while the previous result is unread.
// reset clears all cluster state and loads the default register values.
module scan_cluster_width_detector_core import scwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        range_mm,
	input  logic               last_in_scan,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [9:0]         first_index,
	output logic signed [16:0] pos_x_mm,
	output logic signed [16:0] pos_y_mm,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	logic [15:0] angle_start_q, angle_step_q, join_q, wmin_q, wmax_q;
	logic  push, full, pop, nempty;
	item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= 16'd0;
			angle_step_q  <= 16'd182;
			join_q        <= 16'd150;
			wmin_q        <= 16'd250;
			wmax_q        <= 16'd300;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ANGLE_START: angle_start_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_JOIN_DIST:   join_q        <= cfg_data;
				REG_WIDTH_MIN:   wmin_q        <= cfg_data;
				REG_WIDTH_MAX:   wmax_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	scwd_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .range_mm, .last_in_scan,
		.angle_start(angle_start_q), .angle_step(angle_step_q),
		.q_push(push), .q_item(push_item), .q_full(full)
	);

	scwd_queue u_queue (
		.clk, .arst_n, .push, .push_item, .full, .pop, .pop_item, .not_empty(nempty)
	);

	scwd_back u_back (
		.clk, .arst_n, .q_valid(nempty), .q_item(pop_item), .q_pop(pop),
		.join_distance_mm(join_q), .width_min_mm(wmin_q), .width_max_mm(wmax_q),
		.out_valid, .out_ready, .found, .first_index, .pos_x_mm, .pos_y_mm
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty) else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (first_index == '0 && pos_x_mm == '0))
		else $error("empty result carries data");
endmodule

// ===== test/scwd_checker.sv =====
// ----------------------------------------------------------------------------
// scwd_checker
// Watches the sample, result and register channels of the detector. For every
// accepted sample it converts the range to xy, follows the clustering and the
// width judgement, and queues the scan result due on the last sample. Each
// result transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module scwd_checker import scwd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [15:0]        range_mm,
	input  logic               last_in_scan,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               found,
	input  logic [9:0]         first_index,
	input  logic signed [16:0] pos_x_mm,
	input  logic signed [16:0] pos_y_mm,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 pending,
	output int                 errors
);

	typedef struct {
		bit        found;
		bit [9:0]  index;
		bit [16:0] x;
		bit [16:0] y;
	} scan_result_t;

	localparam longint ARCTAN [24] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0
	};

	scan_result_t scan_results_q[$];

	logic [15:0] ang_start, ang_step, join_mm, wmin_mm, wmax_mm;
	int unsigned next_idx, open_idx, hit_idx;
	longint prv_x, prv_y, open_x, open_y, hit_x, hit_y;
	bit hit;

	function automatic longint clamp17(input longint v);
		if (v < -65536) return -65536;
		if (v > 65535) return 65535;
		return v;
	endfunction

	function automatic void polar_to_cart(input longint r, input int unsigned idx,
			output longint ox, output longint oy);
		longint a, z, cx, cy, dx, dy, c, s;
		int q;
		a = (longint'(ang_start) + longint'(idx) * longint'(ang_step)) & 64'hffff;
		q = int'(a >> 14);
		z = (a & 64'h3fff) << 8;
		cx = (longint'(CORDIC_K_Q30) + (64'sd1 << (29 - TRIG_FRAC_BITS)))
			>>> (30 - TRIG_FRAC_BITS);
		cy = 0;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx; cy += dy; z -= ARCTAN[i];
			end else begin
				cx += dx; cy -= dy; z += ARCTAN[i];
			end
		end
		case (q)
			0: begin c = cx;  s = cy;  end
			1: begin c = -cy; s = cx;  end
			2: begin c = -cx; s = -cy; end
			default: begin c = cy; s = -cx; end
		endcase
		ox = clamp17((r * c + (64'sd1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS);
		oy = clamp17((r * s + (64'sd1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS);
	endfunction

	function automatic void judge_width(input longint ex, input longint ey);
		longint dx, dy, w2;
		dx = ex - open_x;
		dy = ey - open_y;
		w2 = dx * dx + dy * dy;
		if (!hit && w2 >= longint'(wmin_mm) * wmin_mm && w2 <= longint'(wmax_mm) * wmax_mm) begin
			hit = 1;
			hit_idx = open_idx;
			hit_x = open_x;
			hit_y = open_y;
		end
	endfunction

	function automatic void clear_scan();
		next_idx = 0; open_idx = 0; hit_idx = 0;
		prv_x = 0; prv_y = 0; open_x = 0; open_y = 0;
		hit_x = 0; hit_y = 0; hit = 0;
	endfunction

	function automatic void take_sample(input logic [15:0] r, input logic last);
		longint x, y, dx, dy;
		scan_result_t res;
		polar_to_cart(longint'(r), next_idx, x, y);
		if (next_idx == 0) begin
			open_x = x; open_y = y; open_idx = 0;
		end else begin
			dx = x - prv_x;
			dy = y - prv_y;
			if (dx * dx + dy * dy >= longint'(join_mm) * join_mm) begin
				judge_width(prv_x, prv_y);
				open_x = x; open_y = y; open_idx = next_idx;
			end
		end
		prv_x = x;
		prv_y = y;
		if (!last) begin
			if (next_idx < MAX_POINTS - 1)
				next_idx++;
		end else begin
			judge_width(x, y);
			res.found = hit;
			res.index = hit ? hit_idx[9:0] : '0;
			res.x = hit ? hit_x[16:0] : '0;
			res.y = hit ? hit_y[16:0] : '0;
			scan_results_q = {scan_results_q, res};
			clear_scan();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scan_result_t want;
		if (!arst_n) begin
			ang_start = 16'd0;
			ang_step = 16'd182;
			join_mm = 16'd150;
			wmin_mm = 16'd250;
			wmax_mm = 16'd300;
			clear_scan();
			scan_results_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (scan_results_q.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					want = scan_results_q.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						errors++;
					end
					if (first_index !== want.index) begin
						$error("first_index: expected %0d, got %0d", want.index, first_index);
						errors++;
					end
					if (pos_x_mm !== want.x) begin
						$error("pos_x_mm: expected %0d, got %0d",
							$signed(want.x), pos_x_mm);
						errors++;
					end
					if (pos_y_mm !== want.y) begin
						$error("pos_y_mm: expected %0d, got %0d",
							$signed(want.y), pos_y_mm);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ANGLE_START: ang_start = cfg_data;
					REG_ANGLE_STEP:  ang_step = cfg_data;
					REG_JOIN_DIST:   join_mm = cfg_data;
					REG_WIDTH_MIN:   wmin_mm = cfg_data;
					REG_WIDTH_MAX:   wmax_mm = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_sample(range_mm, last_in_scan);
		end
		pending = scan_results_q.size();
	end

endmodule

// ===== test/scan_cluster_width_detector_core_test.sv =====
// ----------------------------------------------------------------------------
// scan_cluster_width_detector_core_test
// Drives scans of lidar samples through the detector under several register
// settings and flow-control patterns; the checker predicts every result.
// ----------------------------------------------------------------------------
module scan_cluster_width_detector_core_test;
	import scwd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        range_mm;
	logic               last_in_scan;
	logic               out_valid;
	logic               out_ready;
	logic               found;
	logic [9:0]         first_index;
	logic signed [16:0] pos_x_mm;
	logic signed [16:0] pos_y_mm;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	int                 pending;
	int                 errors;
	int                 cycles;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 hold_left;
	bit                 hold_req;
	bit                 hold_taken;
	int                 sample_total;

	scan_cluster_width_detector_core i_dut (.*);

	scwd_checker i_checker (.*);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side back-pressure, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= 3000;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ready is sampled in the low phase, where it is settled for the next edge
	task automatic send_sample(input logic [15:0] r, input logic last);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		range_mm <= r;
		last_in_scan <= last;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		sample_total++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
	endtask

	task automatic set_regs(input logic [15:0] a0, input logic [15:0] st,
			input logic [15:0] jd, input logic [15:0] lo, input logic [15:0] hi);
		write_reg(REG_ANGLE_START, a0);
		write_reg(REG_ANGLE_STEP, st);
		write_reg(REG_JOIN_DIST, jd);
		write_reg(REG_WIDTH_MIN, lo);
		write_reg(REG_WIDTH_MAX, hi);
		cfg_valid <= 1'b0;
	endtask

	// wait for every result, then let a sample still in the back end finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// scan made of flat segments (objects) with small jitter, and some noise
	task automatic run_scan(input int len);
		int seg_left;
		int base;
		int r;
		seg_left = 0;
		base = 1000;
		for (int k = 0; k < len; k++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(24, 1);
				base = $urandom_range(4000, 300);
			end
			seg_left--;
			if ($urandom_range(9) == 0)
				r = $urandom_range(65535);
			else
				r = base + $urandom_range(10) - 5;
			send_sample(r[15:0], k == len - 1);
		end
	endtask

	initial begin
		int ph;
		int target;
		logic [15:0] lo;
		arst_n = 1'b0;
		in_valid = 1'b0;
		range_mm = '0;
		last_in_scan = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ANGLE_START;
		cfg_data = '0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		hold_req = 0;
		hold_taken = 0;
		sample_total = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: single-sample scans at both range extremes,
		// then a flat object about 260 mm wide
		send_sample(16'd0, 1'b1);
		send_sample(16'hffff, 1'b1);
		for (int k = 0; k < 16; k++)
			send_sample(16'd1000, 1'b0);
		send_sample(16'd4000, 1'b1);
		drain();

		for (ph = 0; ph < 14; ph++) begin
			case (ph)
				// zero join and zero window: every point is its own cluster
				0: set_regs(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0);
				1: set_regs(16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
				// inverted window
				2: set_regs(16'($urandom), 16'd182, 16'd150, 16'd300, 16'd250);
				default: begin
					if ($urandom_range(3) == 0) begin
						set_regs(16'($urandom), 16'($urandom), 16'($urandom),
							16'($urandom), 16'($urandom));
					end else begin
						lo = 16'($urandom_range(400, 50));
						set_regs(16'($urandom), 16'($urandom_range(400, 60)),
							16'($urandom_range(400, 40)), lo,
							16'(lo + $urandom_range(250)));
					end
				end
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			if (ph == 4)
				hold_req = 1;
			target = sample_total + 45;
			while (sample_total < target)
				run_scan($urandom_range(40, 1));
			drain();
		end

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
